// ----- hw/rtl/lfcb_pkg.sv -----
// Shared types and functions for the LIN frame checksum builder.
`timescale 1ns / 1ps
package lfcb_pkg;

	localparam int QueueDepth = 3;
	localparam int CountW = $clog2(QueueDepth + 1);
	localparam int IdxW = $clog2(QueueDepth);
	localparam logic [7:0] ChecksumBase = 8'hFF;

	typedef struct packed {
		logic [7:0] in_byte;
		logic is_ident;
		logic parity_given;
		logic last;
	} lfcb_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic is_checksum;
		logic frame_end;
	} lfcb_out_t;

	typedef struct packed {
		logic first;
		logic second;
	} lfcb_push_t;

	function automatic logic [7:0] make_pid(input logic [7:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id[5:0]};
	endfunction

	function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

endpackage

// ----- hw/rtl/lfcb_sum_unit.sv -----
// Protected ID, running sum with end-around carry and checksum result.
`timescale 1ns / 1ps
module lfcb_sum_unit import lfcb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  lfcb_in_t   item,
	input  logic       model,
	output lfcb_push_t push,
	output lfcb_out_t  word0,
	output lfcb_out_t  word1
);

	logic [7:0] sum_q;
	logic [7:0] pid;
	logic [7:0] sum_new;

	always_comb begin
		pid = item.parity_given ? item.in_byte : make_pid(item.in_byte);
		if (item.is_ident) begin
			sum_new = model ? pid : 8'd0;
		end else begin
			sum_new = eac_add(sum_q, item.in_byte);
		end
		word0.out_byte = item.is_ident ? pid : item.in_byte;
		word0.is_checksum = 1'b0;
		word0.frame_end = 1'b0;
		word1.out_byte = ChecksumBase - sum_new;
		word1.is_checksum = 1'b1;
		word1.frame_end = 1'b1;
		push.first = fire;
		push.second = fire & item.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= 8'd0;
		end else if (fire) begin
			sum_q <= item.last ? 8'd0 : sum_new;
		end
	end

	a_sum_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.last) |=> (sum_q == 8'd0))
		else $error("running sum not cleared after frame end");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> push.first)
		else $error("checksum pushed without its byte");

endmodule

// ----- hw/rtl/lfcb_out_queue.sv -----
// Three-entry result queue, two pushes and one pop per cycle.
`timescale 1ns / 1ps
module lfcb_out_queue import lfcb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lfcb_push_t push,
	input  lfcb_out_t  word0,
	input  lfcb_out_t  word1,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output lfcb_out_t  out_data
);

	lfcb_out_t mem_q [QueueDepth];
	lfcb_out_t mem_d [QueueDepth];
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] count_d;
	logic [CountW-1:0] count_pop;
	logic pop;

	assign out_valid = (count_q != '0);
	assign out_data = mem_q[0];
	assign pop = out_valid & out_ready;
	assign count_pop = count_q - {{(CountW-1){1'b0}}, pop};
	assign room = (count_pop <= CountW'(QueueDepth - 2));

	always_comb begin
		mem_d = mem_q;
		count_d = count_pop;
		if (pop) begin
			for (int i = 0; i < QueueDepth - 1; i++) begin
				mem_d[i] = mem_q[i+1];
			end
		end
		if (push.first) begin
			mem_d[count_d[IdxW-1:0]] = word0;
			count_d = count_d + CountW'(1);
		end
		if (push.second) begin
			mem_d[count_d[IdxW-1:0]] = word1;
			count_d = count_d + CountW'(1);
		end
	end

	always_ff @(posedge clk) begin
		mem_q <= mem_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.first |-> room)
		else $error("result queue pushed without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(QueueDepth))
		else $error("result queue count out of range");

endmodule

// ----- hw/rtl/lin_frame_checksum_builder_unit.sv -----
// Top level of the LIN frame checksum builder.
// An accepted word waits in the input stage and is pushed when the queue has room.
// Throughput: one input word per cycle while the queue has room; a last word adds
// one checksum result. With results taken every cycle the queue absorbs one extra
// checksum; each further last word in a steady stream then holds off input.
// Reset clears the running sum, the checksum model, the input stage and the queue.
`timescale 1ns / 1ps
module lin_frame_checksum_builder_unit import lfcb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  lfcb_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output lfcb_out_t out_data
);

	logic       model_q;
	logic       valid_s1;
	lfcb_in_t   item_s1;
	logic       room;
	logic       advance;
	logic       accept;
	lfcb_push_t push;
	lfcb_out_t  word0;
	lfcb_out_t  word1;

	assign advance = valid_s1 & room;
	assign in_ready = ~valid_s1 | room;
	assign accept = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				model_q <= cfg_wdata;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	lfcb_sum_unit u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.model  (model_q),
		.push   (push),
		.word0  (word0),
		.word1  (word1)
	);

	lfcb_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.word0     (word0),
		.word1     (word1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
